// ----- sv/dsf_pkg.sv -----
// Shared types and constants for the damped spring follower step block.
package dsf_pkg;

  localparam int UW = 96;   // unit operand / result width
  localparam int DW = 64;   // divisor width
  localparam int MW = 48;   // multiplier operand width

  typedef logic [1:0] dsf_op_t;

  localparam dsf_op_t OP_MUL  = 2'd0;
  localparam dsf_op_t OP_DIV  = 2'd1;
  localparam dsf_op_t OP_SQRT = 2'd2;

  localparam logic [6:0] MUL_STEPS  = 7'd48;
  localparam logic [6:0] DIV_STEPS  = 7'd96;
  localparam logic [6:0] SQRT_STEPS = 7'd44;

  typedef struct packed {
    logic          start;
    dsf_op_t       op;
    logic [UW-1:0] a;
    logic [DW-1:0] b;
  } dsf_req_t;

  typedef struct packed {
    logic          done;
    logic [UW-1:0] res;
  } dsf_rsp_t;

endpackage

// ----- sv/dsf_arith.sv -----
// Bit-serial shared unit: multiply, restoring divide and integer square root.
module dsf_arith (
  input  logic              clk,
  input  logic              rst_n,
  input  dsf_pkg::dsf_req_t req,
  output dsf_pkg::dsf_rsp_t rsp
);

  logic             busy_r;
  logic             done_r;
  dsf_pkg::dsf_op_t op_r;
  logic [6:0]       cnt_r;
  logic [95:0]      x_r;
  logic [63:0]      y_r;
  logic [64:0]      r_r;

  logic [48:0] mul_sum;
  logic [64:0] div_r2;
  logic        div_ge;
  logic [47:0] sq_rn;
  logic [47:0] sq_trial;
  logic        sq_ge;

  always_comb begin
    mul_sum  = {1'b0, x_r[95:48]} + (x_r[0] ? {1'b0, y_r[47:0]} : 49'd0);
    div_r2   = {r_r[63:0], x_r[95]};
    div_ge   = div_r2 >= {1'b0, y_r};
    sq_rn    = {r_r[45:0], x_r[95:94]};
    sq_trial = {2'b00, y_r[43:0], 2'b01};
    sq_ge    = sq_rn >= sq_trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        op_r   <= req.op;
        r_r    <= '0;
        unique case (req.op)
          dsf_pkg::OP_MUL: begin
            x_r   <= {48'd0, req.b[47:0]};
            y_r   <= {16'd0, req.a[47:0]};
            cnt_r <= dsf_pkg::MUL_STEPS;
          end
          dsf_pkg::OP_DIV: begin
            x_r   <= req.a;
            y_r   <= req.b;
            cnt_r <= dsf_pkg::DIV_STEPS;
          end
          default: begin
            x_r   <= {req.a[87:0], 8'd0};
            y_r   <= '0;
            cnt_r <= dsf_pkg::SQRT_STEPS;
          end
        endcase
      end else if (busy_r) begin
        unique case (op_r)
          dsf_pkg::OP_MUL: begin
            x_r <= {mul_sum, x_r[47:1]};
          end
          dsf_pkg::OP_DIV: begin
            r_r <= div_ge ? (div_r2 - {1'b0, y_r}) : div_r2;
            x_r <= {x_r[94:0], div_ge};
          end
          default: begin
            r_r <= {17'd0, sq_ge ? (sq_rn - sq_trial) : sq_rn};
            y_r <= {y_r[62:0], sq_ge};
            x_r <= {x_r[93:0], 2'b00};
          end
        endcase
        cnt_r <= cnt_r - 7'd1;
        if (cnt_r == 7'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.res  = (op_r == dsf_pkg::OP_SQRT) ? {52'd0, y_r[43:0]} : x_r;

endmodule

// ----- sv/damped_spring_follower_step.sv -----
// Damped spring follower: one semi-implicit Euler step per transaction, Q16.16.
// Optional parts of a step: damping scale, travel cap and sphere projection.
// Throughput: one transaction at a time; all multiplies, divides and square
// roots run through one bit-serial unit.
// Reset: synchronous; position and velocity clear, configuration registers take defaults.
module damped_spring_follower_step (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_cmd,
  input  logic [31:0] in_target_x,
  input  logic [31:0] in_target_y,
  input  logic [31:0] in_target_z,
  input  logic [31:0] in_base_vel_x,
  input  logic [31:0] in_base_vel_y,
  input  logic [31:0] in_base_vel_z,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_pos_x,
  output logic [31:0] out_pos_y,
  output logic [31:0] out_pos_z,
  output logic [31:0] out_vel_x,
  output logic [31:0] out_vel_y,
  output logic [31:0] out_vel_z
);

  localparam logic [2:0] CFG_STIFF = 3'd0;
  localparam logic [2:0] CFG_DAMP  = 3'd1;
  localparam logic [2:0] CFG_RT    = 3'd2;
  localparam logic [2:0] CFG_DLON  = 3'd3;
  localparam logic [2:0] CFG_MD    = 3'd4;
  localparam logic [2:0] CFG_PINZ  = 3'd5;
  localparam logic [2:0] CFG_DT    = 3'd6;
  localparam logic [2:0] CFG_RATE  = 3'd7;

  localparam logic [5:0] ST_IDLE  = 6'd0;
  localparam logic [5:0] ST_WAIT  = 6'd1;
  localparam logic [5:0] ST_OUT   = 6'd2;
  localparam logic [5:0] ST_BV_GO = 6'd3;
  localparam logic [5:0] ST_BV_DN = 6'd4;
  localparam logic [5:0] ST_E_GO  = 6'd5;
  localparam logic [5:0] ST_E_DN  = 6'd6;
  localparam logic [5:0] ST_RT_GO = 6'd7;
  localparam logic [5:0] ST_RT_DN = 6'd8;
  localparam logic [5:0] ST_SC_GO = 6'd9;
  localparam logic [5:0] ST_SC_DN = 6'd10;
  localparam logic [5:0] ST_A1_GO = 6'd11;
  localparam logic [5:0] ST_A1_DN = 6'd12;
  localparam logic [5:0] ST_A2_GO = 6'd13;
  localparam logic [5:0] ST_A2_DN = 6'd14;
  localparam logic [5:0] ST_DV_GO = 6'd15;
  localparam logic [5:0] ST_DV_DN = 6'd16;
  localparam logic [5:0] ST_DS_GO = 6'd17;
  localparam logic [5:0] ST_DS_DN = 6'd18;
  localparam logic [5:0] ST_WW_GO = 6'd19;
  localparam logic [5:0] ST_WW_DN = 6'd20;
  localparam logic [5:0] ST_SQ_GO = 6'd21;
  localparam logic [5:0] ST_SQ_DN = 6'd22;
  localparam logic [5:0] ST_TR_GO = 6'd23;
  localparam logic [5:0] ST_TR_DN = 6'd24;
  localparam logic [5:0] ST_CP_GO = 6'd25;
  localparam logic [5:0] ST_CP_DN = 6'd26;
  localparam logic [5:0] ST_CQ_GO = 6'd27;
  localparam logic [5:0] ST_CQ_DN = 6'd28;
  localparam logic [5:0] ST_NP_GO = 6'd29;
  localparam logic [5:0] ST_NP_DN = 6'd30;
  localparam logic [5:0] ST_D_GO  = 6'd31;
  localparam logic [5:0] ST_D_DN  = 6'd32;
  localparam logic [5:0] ST_MD_GO = 6'd33;
  localparam logic [5:0] ST_MD_DN = 6'd34;
  localparam logic [5:0] ST_DM_GO = 6'd35;
  localparam logic [5:0] ST_DM_DN = 6'd36;
  localparam logic [5:0] ST_PM_GO = 6'd37;
  localparam logic [5:0] ST_PM_DN = 6'd38;
  localparam logic [5:0] ST_PQ_GO = 6'd39;
  localparam logic [5:0] ST_PQ_DN = 6'd40;
  localparam logic [5:0] ST_V_GO  = 6'd41;
  localparam logic [5:0] ST_V_DN  = 6'd42;

  function automatic logic signed [47:0] sx48(logic [31:0] v);
    return {{16{v[31]}}, v};
  endfunction

  function automatic logic [47:0] mag48(logic signed [47:0] v);
    return v[47] ? (~v + 48'd1) : v;
  endfunction

  function automatic logic signed [31:0] sat32(logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > $signed(64'h0000_0000_7FFF_FFFF)) r = 32'h7FFF_FFFF;
    else if (v < $signed(64'hFFFF_FFFF_8000_0000)) r = 32'h8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  // configuration
  logic [31:0] stiff_r, damp_r, rt_r, md_r, rate_r;
  logic [16:0] dt_r;
  logic        dlon_r, pinz_r;

  // state and scratch
  logic [5:0]         st_r, ret_r;
  logic [1:0]         k_r;
  logic signed [31:0] pos_r [3];
  logic signed [31:0] vel_r [3];
  logic [31:0]        tgt_r [3];
  logic [31:0]        bv_r  [3];
  logic signed [47:0] ea_r  [3];
  logic signed [47:0] wa_r  [3];
  logic signed [63:0] tmp_r;
  logic [95:0]        ss_r;
  logic [63:0]        trav_r;
  logic [31:0]        scale_r;
  logic               neg_r, sh32_r;
  logic               out_valid_r;
  logic [31:0]        opx_r, opy_r, opz_r, ovx_r, ovy_r, ovz_r;

  dsf_pkg::dsf_req_t req;
  dsf_pkg::dsf_rsp_t rsp;

  dsf_arith u_arith (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (req),
    .rsp  (rsp)
  );

  logic signed [31:0] pk, vk;
  logic [31:0]        tk, bk;
  logic signed [47:0] eak, wak, e_new, d_new, vdiff;
  logic signed [31:0] p_sat;
  logic               damp_gt;
  logic [95:0]        rsum;
  logic [63:0]        rmag;
  logic signed [63:0] rnd, quot, acc;
  logic signed [63:0] pos_sum;
  logic signed [47:0] acc_sat;
  logic               go, gneg, gsh32;
  dsf_pkg::dsf_op_t   gop;
  logic [95:0]        ga;
  logic [63:0]        gb;
  logic [5:0]         gret;
  logic               out_free, in_acc;

  always_comb begin
    pk      = pos_r[k_r];
    vk      = vel_r[k_r];
    tk      = tgt_r[k_r];
    bk      = bv_r[k_r];
    eak     = ea_r[k_r];
    wak     = wa_r[k_r];
    e_new   = sx48(tk) - sx48(pk);
    d_new   = eak - sx48(tk);
    p_sat   = sat32({{16{eak[47]}}, eak});
    vdiff   = sx48(p_sat) - sx48(pk);
    damp_gt = damp_r > rate_r;
    rsum    = rsp.res + (sh32_r ? 96'h8000_0000 : 96'h8000);
    rmag    = sh32_r ? rsum[95:32] : rsum[79:16];
    rnd     = neg_r ? -$signed(rmag) : $signed(rmag);
    quot    = neg_r ? -$signed(rsp.res[63:0]) : $signed(rsp.res[63:0]);
    pos_sum = {{32{pk[31]}}, pk} + rnd;
    acc     = tmp_r - rnd;
    if (acc > $signed(64'h0000_00FF_FFFF_FFFF)) acc_sat = 48'h00FF_FFFF_FFFF;
    else if (acc < $signed(64'hFFFF_FF00_0000_0000)) acc_sat = 48'hFF00_0000_0000;
    else acc_sat = acc[47:0];
  end

  always_comb begin
    go    = 1'b1;
    gop   = dsf_pkg::OP_MUL;
    ga    = '0;
    gb    = '0;
    gneg  = 1'b0;
    gsh32 = 1'b0;
    gret  = ST_IDLE;
    unique case (st_r)
      ST_BV_GO: begin
        ga = {48'd0, mag48(sx48(bk))}; gb = {47'd0, dt_r};
        gneg = bk[31]; gret = ST_BV_DN;
      end
      ST_E_GO: begin
        ga = {48'd0, mag48(e_new)}; gb = {16'd0, mag48(e_new)}; gret = ST_E_DN;
      end
      ST_RT_GO: begin
        ga = {64'd0, rt_r}; gb = {32'd0, rt_r}; gret = ST_RT_DN;
      end
      ST_SC_GO: begin
        gop = dsf_pkg::OP_DIV; ga = {32'd0, rate_r, 32'd0}; gb = {32'd0, damp_r};
        gret = ST_SC_DN;
      end
      ST_A1_GO: begin
        ga = {48'd0, mag48(eak)}; gb = {32'd0, stiff_r}; gneg = eak[47]; gret = ST_A1_DN;
      end
      ST_A2_GO: begin
        ga = {48'd0, mag48(sx48(vk))}; gb = {32'd0, damp_r}; gneg = vk[31];
        gret = ST_A2_DN;
      end
      ST_DV_GO: begin
        ga = {48'd0, mag48(tmp_r[47:0])}; gb = {47'd0, dt_r}; gneg = tmp_r[63];
        gret = ST_DV_DN;
      end
      ST_DS_GO: begin
        ga = {48'd0, mag48(tmp_r[47:0])}; gb = {32'd0, scale_r}; gneg = tmp_r[63];
        gsh32 = 1'b1; gret = ST_DS_DN;
      end
      ST_WW_GO: begin
        ga = {48'd0, mag48(wak)}; gb = {16'd0, mag48(wak)}; gret = ST_WW_DN;
      end
      ST_SQ_GO: begin
        gop = dsf_pkg::OP_SQRT; ga = ss_r; gret = ST_SQ_DN;
      end
      ST_TR_GO: begin
        ga = {48'd0, trav_r[47:0]}; gb = {47'd0, dt_r}; gret = ST_TR_DN;
      end
      ST_CP_GO: begin
        ga = {48'd0, mag48(wak)}; gb = {16'd0, rt_r, 16'd0}; gneg = wak[47];
        gret = ST_CP_DN;
      end
      ST_CQ_GO: begin
        gop = dsf_pkg::OP_DIV; ga = ss_r; gb = trav_r; gneg = wak[47]; gret = ST_CQ_DN;
      end
      ST_NP_GO: begin
        ga = {48'd0, mag48(wak)}; gb = {47'd0, dt_r}; gneg = wak[47]; gret = ST_NP_DN;
      end
      ST_D_GO: begin
        ga = {48'd0, mag48(d_new)}; gb = {16'd0, mag48(d_new)}; gret = ST_D_DN;
      end
      ST_MD_GO: begin
        ga = {64'd0, md_r}; gb = {32'd0, md_r}; gret = ST_MD_DN;
      end
      ST_DM_GO: begin
        gop = dsf_pkg::OP_SQRT; ga = ss_r; gret = ST_DM_DN;
      end
      ST_PM_GO: begin
        ga = {48'd0, mag48(wak)}; gb = {32'd0, md_r}; gneg = wak[47]; gret = ST_PM_DN;
      end
      ST_PQ_GO: begin
        gop = dsf_pkg::OP_DIV; ga = ss_r; gb = trav_r; gneg = wak[47]; gret = ST_PQ_DN;
      end
      ST_V_GO: begin
        ga = {48'd0, mag48(vdiff)}; gb = {32'd0, rate_r}; gneg = vdiff[47];
        gret = ST_V_DN;
      end
      default: go = 1'b0;
    endcase
    req.start = go;
    req.op    = gop;
    req.a     = ga;
    req.b     = gb;
  end

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (st_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stiff_r <= 32'd3276800;
      damp_r  <= 32'd262144;
      rt_r    <= 32'd16777216;
      dlon_r  <= 1'b0;
      md_r    <= 32'd0;
      pinz_r  <= 1'b0;
      dt_r    <= 17'd546;
      rate_r  <= 32'd7864320;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_STIFF: stiff_r <= cfg_wdata;
        CFG_DAMP:  damp_r  <= cfg_wdata;
        CFG_RT:    rt_r    <= cfg_wdata;
        CFG_DLON:  dlon_r  <= cfg_wdata[0];
        CFG_MD:    md_r    <= cfg_wdata;
        CFG_PINZ:  pinz_r  <= cfg_wdata[0];
        CFG_DT:    dt_r    <= cfg_wdata[16:0];
        CFG_RATE:  rate_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      k_r         <= 2'd0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        pos_r[i] <= '0;
        vel_r[i] <= '0;
      end
    end else begin
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      if (go) begin
        st_r   <= ST_WAIT;
        ret_r  <= gret;
        neg_r  <= gneg;
        sh32_r <= gsh32;
      end
      unique case (st_r)
        ST_IDLE: begin
          if (in_acc) begin
            tgt_r[0] <= in_target_x;
            tgt_r[1] <= in_target_y;
            tgt_r[2] <= in_target_z;
            bv_r[0]  <= in_base_vel_x;
            bv_r[1]  <= in_base_vel_y;
            bv_r[2]  <= in_base_vel_z;
            k_r      <= 2'd0;
            if (!in_cmd) begin
              pos_r[0] <= in_target_x;
              pos_r[1] <= in_target_y;
              pos_r[2] <= in_target_z;
              for (int i = 0; i < 3; i++) vel_r[i] <= '0;
              st_r <= ST_OUT;
            end else begin
              st_r <= ST_BV_GO;
            end
          end
        end
        ST_WAIT: begin
          if (rsp.done) st_r <= ret_r;
        end
        ST_BV_DN: begin
          pos_r[k_r] <= sat32(pos_sum);
          if (k_r == 2'd2) begin
            k_r <= 2'd0; ss_r <= '0; st_r <= ST_E_GO;
          end else begin
            k_r <= k_r + 2'd1; st_r <= ST_BV_GO;
          end
        end
        ST_E_GO: ea_r[k_r] <= e_new;
        ST_E_DN: begin
          ss_r <= ss_r + rsp.res;
          if (k_r == 2'd2) begin
            k_r <= 2'd0; st_r <= ST_RT_GO;
          end else begin
            k_r <= k_r + 2'd1; st_r <= ST_E_GO;
          end
        end
        ST_RT_DN: begin
          if (ss_r > rsp.res) begin
            for (int i = 0; i < 3; i++) begin
              pos_r[i] <= tgt_r[i];
              vel_r[i] <= '0;
              ea_r[i]  <= '0;
            end
          end
          st_r <= damp_gt ? ST_SC_GO : ST_A1_GO;
        end
        ST_SC_DN: begin
          scale_r <= rsp.res[31:0];
          st_r    <= ST_A1_GO;
        end
        ST_A1_DN: begin
          tmp_r <= rnd;
          st_r  <= ST_A2_GO;
        end
        ST_A2_DN: begin
          tmp_r <= {{16{acc_sat[47]}}, acc_sat};
          st_r  <= ST_DV_GO;
        end
        ST_DV_DN: begin
          if (damp_gt) begin
            tmp_r <= rnd;
            st_r  <= ST_DS_GO;
          end else begin
            wa_r[k_r] <= sx48(vk) + rnd[47:0];
            if (k_r == 2'd2) begin
              k_r <= 2'd0; ss_r <= '0; st_r <= ST_WW_GO;
            end else begin
              k_r <= k_r + 2'd1; st_r <= ST_A1_GO;
            end
          end
        end
        ST_DS_DN: begin
          wa_r[k_r] <= sx48(vk) + rnd[47:0];
          if (k_r == 2'd2) begin
            k_r <= 2'd0; ss_r <= '0; st_r <= ST_WW_GO;
          end else begin
            k_r <= k_r + 2'd1; st_r <= ST_A1_GO;
          end
        end
        ST_WW_DN: begin
          ss_r <= ss_r + rsp.res;
          if (k_r == 2'd2) begin
            k_r <= 2'd0; st_r <= ST_SQ_GO;
          end else begin
            k_r <= k_r + 2'd1; st_r <= ST_WW_GO;
          end
        end
        ST_SQ_DN: begin
          trav_r <= rsp.res[63:0];
          st_r   <= ST_TR_GO;
        end
        ST_TR_DN: begin
          trav_r <= rsp.res[63:0];
          k_r    <= 2'd0;
          st_r   <= (rsp.res[63:0] > {16'd0, rt_r, 16'd0}) ? ST_CP_GO : ST_NP_GO;
        end
        ST_CP_DN: begin
          ss_r <= rsp.res;
          st_r <= ST_CQ_GO;
        end
        ST_CQ_DN: begin
          wa_r[k_r] <= quot[47:0];
          if (k_r == 2'd2) begin
            k_r <= 2'd0; st_r <= ST_NP_GO;
          end else begin
            k_r <= k_r + 2'd1; st_r <= ST_CP_GO;
          end
        end
        ST_NP_DN: begin
          if (k_r == 2'd2 && pinz_r) ea_r[k_r] <= sx48(tk);
          else ea_r[k_r] <= sx48(pk) + rnd[47:0];
          if (k_r == 2'd2) begin
            k_r  <= 2'd0;
            ss_r <= '0;
            st_r <= dlon_r ? ST_D_GO : ST_V_GO;
          end else begin
            k_r <= k_r + 2'd1; st_r <= ST_NP_GO;
          end
        end
        ST_D_GO: wa_r[k_r] <= d_new;
        ST_D_DN: begin
          ss_r <= ss_r + rsp.res;
          if (k_r == 2'd2) begin
            k_r <= 2'd0; st_r <= ST_MD_GO;
          end else begin
            k_r <= k_r + 2'd1; st_r <= ST_D_GO;
          end
        end
        ST_MD_DN: begin
          st_r <= (ss_r > rsp.res) ? ST_DM_GO : ST_V_GO;
        end
        ST_DM_DN: begin
          trav_r <= rsp.res[63:0];
          st_r   <= ST_PM_GO;
        end
        ST_PM_DN: begin
          ss_r <= rsp.res;
          st_r <= ST_PQ_GO;
        end
        ST_PQ_DN: begin
          ea_r[k_r] <= sx48(tk) + quot[47:0];
          if (k_r == 2'd2) begin
            k_r <= 2'd0; st_r <= ST_V_GO;
          end else begin
            k_r <= k_r + 2'd1; st_r <= ST_PM_GO;
          end
        end
        ST_V_DN: begin
          vel_r[k_r] <= sat32(rnd);
          pos_r[k_r] <= p_sat;
          if (k_r == 2'd2) begin
            k_r <= 2'd0; st_r <= ST_OUT;
          end else begin
            k_r <= k_r + 2'd1; st_r <= ST_V_GO;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            st_r        <= ST_IDLE;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == ST_OUT && out_free) begin
      opx_r <= pos_r[0];
      opy_r <= pos_r[1];
      opz_r <= pos_r[2];
      ovx_r <= vel_r[0];
      ovy_r <= vel_r[1];
      ovz_r <= vel_r[2];
    end
  end

  assign out_valid = out_valid_r;
  assign out_pos_x = opx_r;
  assign out_pos_y = opy_r;
  assign out_pos_z = opz_r;
  assign out_vel_x = ovx_r;
  assign out_vel_y = ovy_r;
  assign out_vel_z = ovz_r;

endmodule
